/* design/rlr_pkg.sv */
package rlr_pkg;

   // register indexes on the csr port
   localparam logic REG_PARTITIONS = 1'b0;
   localparam logic REG_RATIO      = 1'b1;

   // register reset values and limits
   localparam logic [6:0]  PARTITIONS_RESET = 7'd2;
   localparam logic [6:0]  PARTITIONS_FLOOR = 7'd2;
   localparam logic [11:0] RATIO_RESET      = 12'd1399;
   localparam logic [11:0] RATIO_FLOOR      = 12'd256;

   // result field limits
   localparam logic [16:0] COST_MAX = 17'd131071;

   // command broadcast to every cell
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ADD,
      CELL_SHIFT
   } cell_op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INC,
      ST_SCAN,
      ST_CAPTURE,
      ST_DECIDE,
      ST_MERGE,
      ST_SHIFT,
      ST_DONE
   } state_type;

endpackage

/* design/rlr_cell.sv */
module rlr_cell #(
   parameter int LOAD_WIDTH = 16,
   parameter int CNT_W      = 7,
   parameter int CELL_IDX   = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rlr_pkg::cell_op_type    op,
   input  logic [CNT_W-1:0]        count,
   input  logic [CNT_W-1:0]        sel_pos,
   input  logic [CNT_W-1:0]        v_pos,
   input  logic [CNT_W-1:0]        u_pos,
   input  logic [CNT_W-1:0]        u_next,
   input  logic [LOAD_WIDTH-1:0]   add_val,
   input  logic [LOAD_WIDTH-1:0]   down_val,
   input  logic [LOAD_WIDTH-1:0]   up_val,
   input  logic [LOAD_WIDTH-1:0]   left_load,
   input  logic [LOAD_WIDTH-1:0]   right_load,
   output logic [LOAD_WIDTH-1:0]   load,
   // scan token from the previous cell
   input  logic [LOAD_WIDTH-1:0]   tin_min,
   input  logic [CNT_W-1:0]        tin_idx,
   input  logic [LOAD_WIDTH-1:0]   tin_left,
   input  logic [LOAD_WIDTH-1:0]   tin_right,
   input  logic [LOAD_WIDTH-1:0]   tin_first,
   input  logic [LOAD_WIDTH-1:0]   tin_last,
   input  logic [LOAD_WIDTH-1:0]   tin_tgt,
   input  logic [LOAD_WIDTH-1:0]   tin_max,
   // scan token to the next cell
   output logic [LOAD_WIDTH-1:0]   tout_min,
   output logic [CNT_W-1:0]        tout_idx,
   output logic [LOAD_WIDTH-1:0]   tout_left,
   output logic [LOAD_WIDTH-1:0]   tout_right,
   output logic [LOAD_WIDTH-1:0]   tout_first,
   output logic [LOAD_WIDTH-1:0]   tout_last,
   output logic [LOAD_WIDTH-1:0]   tout_tgt,
   output logic [LOAD_WIDTH-1:0]   tout_max
);

   localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(CELL_IDX);
   localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(CELL_IDX + 1);
   localparam bit               IS_HEAD = (CELL_IDX == 0);

   logic [LOAD_WIDTH-1:0] load_ff, load_in;
   logic [LOAD_WIDTH:0]   sum;
   logic [LOAD_WIDTH-1:0] sat_sum;
   logic [LOAD_WIDTH-1:0] b_self, b_left;
   logic                  active;

   logic [LOAD_WIDTH-1:0] min_ff, min_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [LOAD_WIDTH-1:0] left_ff, left_in;
   logic [LOAD_WIDTH-1:0] right_ff, right_in;
   logic [LOAD_WIDTH-1:0] first_ff, first_in;
   logic [LOAD_WIDTH-1:0] last_ff, last_in;
   logic [LOAD_WIDTH-1:0] tgt_ff, tgt_in;
   logic [LOAD_WIDTH-1:0] max_ff, max_in;
   logic                  take_min;

   assign active = (MY_POS < count);

   // saturating add of the broadcast amount
   assign sum     = {1'b0, load_ff} + {1'b0, add_val};
   assign sat_sum = sum[LOAD_WIDTH] ? {LOAD_WIDTH{1'b1}} : sum[LOAD_WIDTH-1:0];

   // ring contents after the lightest slot is removed, here and one slot to the left
   assign b_self = ((v_pos <= MY_POS) && (MY_NEXT < count)) ? right_load : load_ff;
   assign b_left = ((v_pos < MY_POS) && (MY_POS < count)) ? load_ff : left_load;

   // load update
   always_comb begin
      load_in = load_ff;
      case (op)
         rlr_pkg::CELL_ADD: begin
            if (sel_pos == MY_POS) load_in = sat_sum;
         end
         rlr_pkg::CELL_SHIFT: begin
            if (active) begin
               if (MY_POS == u_pos)       load_in = down_val;
               else if (MY_POS == u_next) load_in = up_val;
               else if (MY_POS > u_next)  load_in = b_left;
               else                       load_in = b_self;
            end
         end
         default: load_in = load_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
      end else begin
         load_ff <= load_in;
      end
   end

   assign load = load_ff;

   // scan token: lightest slot with its ring neighbors, plus target, ends and max
   assign take_min = active && (IS_HEAD || (load_ff < tin_min));

   always_comb begin
      min_in   = take_min ? load_ff : tin_min;
      idx_in   = take_min ? MY_POS : tin_idx;
      left_in  = take_min ? left_load : tin_left;
      first_in = IS_HEAD ? load_ff : tin_first;
      right_in = tin_right;
      if (take_min) right_in = (MY_NEXT == count) ? first_in : right_load;
      last_in  = (MY_NEXT == count) ? load_ff : tin_last;
      tgt_in   = (active && (MY_POS == sel_pos)) ? load_ff : tin_tgt;
      max_in   = (active && (IS_HEAD || (load_ff > tin_max))) ? load_ff : tin_max;
   end

   always_ff @(posedge clock) begin
      min_ff   <= min_in;
      idx_ff   <= idx_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      tgt_ff   <= tgt_in;
      max_ff   <= max_in;
   end

   assign tout_min   = min_ff;
   assign tout_idx   = idx_ff;
   assign tout_left  = left_ff;
   assign tout_right = right_ff;
   assign tout_first = first_ff;
   assign tout_last  = last_ff;
   assign tout_tgt   = tgt_ff;
   assign tout_max   = max_ff;

endmodule

/* design/ring_load_rebalancer_unit.sv */
// one request at a time: the next can be taken in the cycle after the result is
// registered; the scan token walks one cell a cycle down the chain of cells
// synchronous active-high reset clears all loads, the count to 2 and the ratio
// to 1399; it is ready for a request in the cycle after reset falls
module ring_load_rebalancer_unit #(
   parameter int MAX_PARTITIONS = 64,
   parameter int LOAD_WIDTH     = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] target_partition, [7:6] zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [0] rebalanced, [17:1] step_cost,
                                    // [33:18] min_load, [49:34] max_load, [55:50] zero
   // configuration writes
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [11:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam int PROD_W = LOAD_WIDTH + 12;
   localparam int SUM_W = (LOAD_WIDTH + 2 > 17) ? LOAD_WIDTH + 2 : 17;
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_PARTITIONS - 1);
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PARTITIONS);

   // configuration registers
   logic [6:0]  parts_ff;
   logic [11:0] ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         parts_ff <= rlr_pkg::PARTITIONS_RESET;
         ratio_ff <= rlr_pkg::RATIO_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            rlr_pkg::REG_PARTITIONS: parts_ff <= csr_wdata[6:0];
            rlr_pkg::REG_RATIO:      ratio_ff <= csr_wdata;
            default:                 parts_ff <= parts_ff;
         endcase
      end
   end

   // active count and ratio clamped to their legal ranges
   logic [CMP_W-1:0] parts_cmp;
   logic [CNT_W-1:0] count;
   logic [11:0]      ratio_eff;

   always_comb begin
      parts_cmp = CMP_W'(parts_ff);
      if (parts_ff < rlr_pkg::PARTITIONS_FLOOR) parts_cmp = CMP_W'(rlr_pkg::PARTITIONS_FLOOR);
      else if (parts_cmp > MAX_CMP)             parts_cmp = MAX_CMP;
      count = CNT_W'(parts_cmp);
   end

   assign ratio_eff = (ratio_ff < rlr_pkg::RATIO_FLOOR) ? rlr_pkg::RATIO_FLOOR : ratio_ff;

   // sequencer and datapath registers
   rlr_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]      scan_cnt_ff;
   logic                  pass2_ff;
   logic                  t_ok_ff;
   logic [CNT_W-1:0]      t_pos_ff;
   logic [LOAD_WIDTH-1:0] mn_ff, mx_ff, tgt_ff, lval_ff, rval_ff, w_ff;
   logic [CNT_W-1:0]      v_ff, z_ff, u_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [16:0]           cost_ff;
   logic                  rsp_valid_ff;
   logic [55:0]           rsp_data_ff;

   logic                  req_fire;
   logic                  t_ok_new;
   logic                  trig;
   logic                  out_free;

   // cell broadcast controls
   rlr_pkg::cell_op_type  cell_op;
   logic [CNT_W-1:0]      sel_pos;
   logic [LOAD_WIDTH-1:0] add_val;
   logic [LOAD_WIDTH-1:0] down_val, up_val;
   logic [LOAD_WIDTH:0]   w_plus;
   logic [CNT_W-1:0]      u_next;

   // cell chain
   logic [LOAD_WIDTH-1:0] load_q    [MAX_PARTITIONS];
   logic [LOAD_WIDTH-1:0] tok_min   [MAX_PARTITIONS];
   logic [CNT_W-1:0]      tok_idx   [MAX_PARTITIONS];
   logic [LOAD_WIDTH-1:0] tok_left  [MAX_PARTITIONS];
   logic [LOAD_WIDTH-1:0] tok_right [MAX_PARTITIONS];
   logic [LOAD_WIDTH-1:0] tok_first [MAX_PARTITIONS];
   logic [LOAD_WIDTH-1:0] tok_last  [MAX_PARTITIONS];
   logic [LOAD_WIDTH-1:0] tok_tgt   [MAX_PARTITIONS];
   logic [LOAD_WIDTH-1:0] tok_max   [MAX_PARTITIONS];

   assign w_plus   = {1'b0, w_ff} + {{LOAD_WIDTH{1'b0}}, 1'b1};
   assign down_val = w_ff >> 1;
   assign up_val   = w_plus[LOAD_WIDTH:1];
   assign u_next   = u_ff + CNT_W'(1);

   for (genvar i = 0; i < MAX_PARTITIONS; i++) begin : g_cell
      logic [LOAD_WIDTH-1:0] left_nb, right_nb;
      logic [LOAD_WIDTH-1:0] ti_min, ti_left, ti_right, ti_first, ti_last, ti_tgt, ti_max;
      logic [CNT_W-1:0]      ti_idx;

      if (i == 0) begin : g_head
         assign left_nb  = '0;
         assign ti_min   = '0;
         assign ti_idx   = '0;
         assign ti_left  = '0;
         assign ti_right = '0;
         assign ti_first = '0;
         assign ti_last  = '0;
         assign ti_tgt   = '0;
         assign ti_max   = '0;
      end else begin : g_link
         assign left_nb  = load_q[i-1];
         assign ti_min   = tok_min[i-1];
         assign ti_idx   = tok_idx[i-1];
         assign ti_left  = tok_left[i-1];
         assign ti_right = tok_right[i-1];
         assign ti_first = tok_first[i-1];
         assign ti_last  = tok_last[i-1];
         assign ti_tgt   = tok_tgt[i-1];
         assign ti_max   = tok_max[i-1];
      end

      if (i == MAX_PARTITIONS - 1) begin : g_tail
         assign right_nb = '0;
      end else begin : g_next
         assign right_nb = load_q[i+1];
      end

      rlr_cell #(
         .LOAD_WIDTH (LOAD_WIDTH),
         .CNT_W      (CNT_W),
         .CELL_IDX   (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (cell_op),
         .count      (count),
         .sel_pos    (sel_pos),
         .v_pos      (v_ff),
         .u_pos      (u_ff),
         .u_next     (u_next),
         .add_val    (add_val),
         .down_val   (down_val),
         .up_val     (up_val),
         .left_load  (left_nb),
         .right_load (right_nb),
         .load       (load_q[i]),
         .tin_min    (ti_min),
         .tin_idx    (ti_idx),
         .tin_left   (ti_left),
         .tin_right  (ti_right),
         .tin_first  (ti_first),
         .tin_last   (ti_last),
         .tin_tgt    (ti_tgt),
         .tin_max    (ti_max),
         .tout_min   (tok_min[i]),
         .tout_idx   (tok_idx[i]),
         .tout_left  (tok_left[i]),
         .tout_right (tok_right[i]),
         .tout_first (tok_first[i]),
         .tout_last  (tok_last[i]),
         .tout_tgt   (tok_tgt[i]),
         .tout_max   (tok_max[i])
      );
   end

   // token leaving the end of the chain
   logic [LOAD_WIDTH-1:0] end_min, end_left, end_right, end_last, end_tgt, end_max;
   logic [CNT_W-1:0]      end_idx;

   assign end_min   = tok_min[MAX_PARTITIONS-1];
   assign end_idx   = tok_idx[MAX_PARTITIONS-1];
   assign end_left  = tok_left[MAX_PARTITIONS-1];
   assign end_right = tok_right[MAX_PARTITIONS-1];
   assign end_last  = tok_last[MAX_PARTITIONS-1];
   assign end_tgt   = tok_tgt[MAX_PARTITIONS-1];
   assign end_max   = tok_max[MAX_PARTITIONS-1];

   // request accept and target range check
   assign req_fire = req_tvalid && req_tready;
   assign t_ok_new = (CMP_W'(req_tdata[5:0]) < parts_cmp);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // trigger test: touched load * 256 against ratio * lightest load
   assign trig = t_ok_ff && (PROD_W'({tgt_ff, 8'b0}) > prod_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rlr_pkg::ST_IDLE: begin
            if (req_fire) state_in = t_ok_new ? rlr_pkg::ST_INC : rlr_pkg::ST_SCAN;
         end
         rlr_pkg::ST_INC:     state_in = rlr_pkg::ST_SCAN;
         rlr_pkg::ST_SCAN: begin
            if (scan_cnt_ff == SCAN_LAST) state_in = rlr_pkg::ST_CAPTURE;
         end
         rlr_pkg::ST_CAPTURE: state_in = pass2_ff ? rlr_pkg::ST_DONE : rlr_pkg::ST_DECIDE;
         rlr_pkg::ST_DECIDE:  state_in = trig ? rlr_pkg::ST_MERGE : rlr_pkg::ST_DONE;
         rlr_pkg::ST_MERGE:   state_in = rlr_pkg::ST_SHIFT;
         rlr_pkg::ST_SHIFT:   state_in = rlr_pkg::ST_SCAN;
         rlr_pkg::ST_DONE: begin
            if (out_free) state_in = rlr_pkg::ST_IDLE;
         end
         default:             state_in = rlr_pkg::ST_IDLE;
      endcase
   end

   // state outputs: handshake and cell commands
   always_comb begin
      req_tready = 1'b0;
      cell_op    = rlr_pkg::CELL_HOLD;
      sel_pos    = t_pos_ff;
      add_val    = mn_ff;
      unique case (state_ff)
         rlr_pkg::ST_IDLE:  req_tready = !reset;
         rlr_pkg::ST_INC: begin
            cell_op = rlr_pkg::CELL_ADD;
            add_val = LOAD_WIDTH'(1);
         end
         rlr_pkg::ST_MERGE: begin
            cell_op = rlr_pkg::CELL_ADD;
            sel_pos = z_ff;
         end
         rlr_pkg::ST_SHIFT: cell_op = rlr_pkg::CELL_SHIFT;
         default:           cell_op = rlr_pkg::CELL_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == rlr_pkg::ST_DONE) && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                            rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   logic [LOAD_WIDTH:0]   merge_sum;
   logic [CNT_W-1:0]      lpos, rpos;
   logic [SUM_W-1:0]      cost_sum;

   assign merge_sum = {1'b0, tgt_ff} + {1'b0, mn_ff};
   assign lpos      = (v_ff == '0) ? count - CNT_W'(1) : v_ff - CNT_W'(1);
   assign rpos      = ((v_ff + CNT_W'(1)) == count) ? '0 : v_ff + CNT_W'(1);
   assign cost_sum  = SUM_W'(1) + SUM_W'(mn_ff) + SUM_W'(up_val);

   always_ff @(posedge clock) begin
      // scan step counter
      if (state_ff == rlr_pkg::ST_SCAN) scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
      else                              scan_cnt_ff <= '0;

      case (state_ff)
         rlr_pkg::ST_IDLE: begin
            if (req_fire) begin
               t_ok_ff  <= t_ok_new;
               t_pos_ff <= CNT_W'(req_tdata[5:0]);
               pass2_ff <= 1'b0;
               cost_ff  <= 17'd1;
            end
         end
         rlr_pkg::ST_CAPTURE: begin
            mn_ff   <= end_min;
            mx_ff   <= end_max;
            v_ff    <= end_idx;
            lval_ff <= (end_idx == '0) ? end_last : end_left;
            rval_ff <= end_right;
            tgt_ff  <= end_tgt;
            prod_ff <= {{LOAD_WIDTH{1'b0}}, ratio_eff} * {12'b0, end_min};
         end
         rlr_pkg::ST_DECIDE: begin
            z_ff <= (lval_ff < rval_ff) ? lpos : rpos;
         end
         rlr_pkg::ST_MERGE: begin
            // touched load after the merge, and its slot once the lightest is gone
            if (z_ff == t_pos_ff)
               w_ff <= merge_sum[LOAD_WIDTH] ? {LOAD_WIDTH{1'b1}} : merge_sum[LOAD_WIDTH-1:0];
            else
               w_ff <= tgt_ff;
            u_ff <= (v_ff < t_pos_ff) ? t_pos_ff - CNT_W'(1) : t_pos_ff;
         end
         rlr_pkg::ST_SHIFT: begin
            cost_ff  <= (cost_sum > SUM_W'(rlr_pkg::COST_MAX)) ? rlr_pkg::COST_MAX
                                                               : cost_sum[16:0];
            pass2_ff <= 1'b1;
         end
         rlr_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_data_ff <= {6'b0, 16'(mx_ff), 16'(mn_ff), cost_ff, pass2_ff};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // a rebalance always moves at least the ceil half of a nonzero load
   a_reb_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[17:1] != 17'd1))
      else $error("rebalance reported with no units moved");

   // reported minimum never exceeds reported maximum
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33:18] <= rsp_tdata[49:34]))
      else $error("min_load above max_load");

   // the touched partition is never the one removed
   a_not_self: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rlr_pkg::ST_SHIFT) |-> (v_ff != t_pos_ff))
      else $error("lightest partition equals touched partition on rebalance");

   // the lightest slot found by the scan lies on the active ring
   a_min_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rlr_pkg::ST_DECIDE) |-> (v_ff < count))
      else $error("lightest slot outside the active ring");
`endif

endmodule

/* test/tb_ring_load_rebalancer_unit.sv */
`timescale 1ns / 1ps

module tb_ring_load_rebalancer_unit;

   localparam int RING_SIZE     = 64;
   localparam int LOAD_LIMIT    = 65535;
   localparam int SETTLE_CYCLES = 2 * RING_SIZE + 24;
   localparam int CYCLE_LIMIT   = 900000;

   // result layout, lowest bit first from the bottom of the struct
   typedef struct packed {
      logic [5:0]  pad;
      logic [15:0] max_load;
      logic [15:0] min_load;
      logic [16:0] step_cost;
      logic        rebalanced;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [5:0] target_partition, [7:6] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // [0] rebalanced, [17:1] step_cost,
                                   // [33:18] min_load, [49:34] max_load
   logic        csr_wen = 1'b0;
   logic        csr_addr = rlr_pkg::REG_PARTITIONS;
   logic [11:0] csr_wdata = '0;

   // predicted ring and register copies
   logic [15:0] load_image [RING_SIZE];
   logic [6:0]  count_setting;
   logic [11:0] ratio_setting;

   logic [5:0]  target_queue [$];
   logic [5:0]  directed_targets [$];
   outcome_type expected_outcomes [$];
   logic [5:0]  hot_target = '0;
   bit          idling_on = 1'b1;
   int          send_gap = 0;
   int          stall_left = 0;
   int          error_count = 0;
   int          requests_taken = 0;
   int          rebalance_seen = 0;
   int          settings_used = 0;

   ring_load_rebalancer_unit #(
      .MAX_PARTITIONS(RING_SIZE),
      .LOAD_WIDTH(16)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // active ring size after clamping the count register
   function automatic int unsigned ring_count();
      if (count_setting < rlr_pkg::PARTITIONS_FLOOR) return rlr_pkg::PARTITIONS_FLOOR;
      if (count_setting > RING_SIZE) return RING_SIZE;
      return count_setting;
   endfunction

   function automatic logic [15:0] clamp_load(input longint unsigned sum);
      return (sum > LOAD_LIMIT) ? 16'(LOAD_LIMIT) : sum[15:0];
   endfunction

   // apply one request to the predicted ring and return its result
   function automatic outcome_type rebalance_step(input logic [5:0] target);
      int unsigned n, t, v, nb_left, nb_right, dest, u, i;
      longint unsigned cost, ratio, whole, grown;
      logic [15:0] moved, upper, lower, lo, hi;
      outcome_type res;
      n = ring_count();
      t = target;
      cost = 1;
      res = '0;
      if (t < n) begin
         grown = load_image[t];
         load_image[t] = clamp_load(grown + 1);
         // lightest partition, lowest index on a tie
         v = 0;
         for (i = 1; i < n; i++)
            if (load_image[i] < load_image[v]) v = i;
         ratio = (ratio_setting < rlr_pkg::RATIO_FLOOR) ? rlr_pkg::RATIO_FLOOR
                                                        : ratio_setting;
         whole = load_image[t];
         if ((whole << 8) > ratio * load_image[v]) begin
            // merge the lightest into its lighter neighbour
            nb_left  = (v == 0) ? n - 1 : v - 1;
            nb_right = (v + 1 == n) ? 0 : v + 1;
            dest = (load_image[nb_left] < load_image[nb_right]) ? nb_left : nb_right;
            moved = load_image[v];
            grown = load_image[dest];
            load_image[dest] = clamp_load(grown + moved);
            cost += moved;
            for (i = v; i + 1 < n; i++) load_image[i] = load_image[i + 1];
            u = (v < t) ? t - 1 : t;
            // split the touched partition, floor half first
            whole = load_image[u];
            upper = 16'((whole + 1) >> 1);
            lower = 16'(whole >> 1);
            for (i = n - 1; i > u; i--) load_image[i] = load_image[i - 1];
            load_image[u] = lower;
            load_image[u + 1] = upper;
            cost += upper;
            res.rebalanced = 1'b1;
         end
      end
      res.step_cost = (cost > rlr_pkg::COST_MAX) ? rlr_pkg::COST_MAX : cost[16:0];
      lo = load_image[0];
      hi = load_image[0];
      for (i = 1; i < n; i++) begin
         if (load_image[i] < lo) lo = load_image[i];
         if (load_image[i] > hi) hi = load_image[i];
      end
      res.min_load = lo;
      res.max_load = hi;
      return res;
   endfunction

   // mostly back to back, sometimes a short gap, rarely a long one
   function automatic int pick_gap();
      int roll;
      if (!idling_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 110);
   endfunction

   // hammer one partition often so the ring gets skewed
   function automatic logic [5:0] pick_target();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return hot_target;
      if (roll < 88) return 6'($urandom_range(0, ring_count() - 1));
      return 6'($urandom_range(0, 63));
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (error_count < 25)
         $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_result(input outcome_type got);
      outcome_type want;
      if (expected_outcomes.size() == 0) begin
         report_mismatch("result with no request outstanding, step_cost",
                         got.step_cost, 0);
      end else begin
         want = expected_outcomes.pop_front();
         if (want.rebalanced) rebalance_seen++;
         if (got.rebalanced !== want.rebalanced)
            report_mismatch("rebalanced", got.rebalanced, want.rebalanced);
         if (got.step_cost !== want.step_cost)
            report_mismatch("step_cost", got.step_cost, want.step_cost);
         if (got.min_load !== want.min_load)
            report_mismatch("min_load", got.min_load, want.min_load);
         if (got.max_load !== want.max_load)
            report_mismatch("max_load", got.max_load, want.max_load);
         if (got.pad !== '0)
            report_mismatch("padding bits", got.pad, 0);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_outcomes.insert(expected_outcomes.size(),
                                     rebalance_step(req_tdata[5:0]));
            requests_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (target_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, target_queue.pop_front()};
               send_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left <= pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // register write while the block is idle
   task automatic write_reg(input logic addr, input logic [11:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (addr == rlr_pkg::REG_PARTITIONS) count_setting = value[6:0];
      else ratio_setting = value;
   endtask

   task automatic wait_idle();
      while (target_queue.size() != 0 || req_tvalid || expected_outcomes.size() != 0)
         @(negedge clock);
   endtask

   // directed requests first, then random ones, then drain
   task automatic run_phase(input int random_items);
      int k;
      @(negedge clock);
      hot_target = 6'($urandom_range(0, ring_count() - 1));
      while (directed_targets.size() > 0)
         target_queue.insert(target_queue.size(), directed_targets.pop_front());
      for (k = 0; k < random_items; k++)
         target_queue.insert(target_queue.size(), pick_target());
      wait_idle();
      settings_used++;
   endtask

   // main sequence
   initial begin
      int i, k;
      for (i = 0; i < RING_SIZE; i++) load_image[i] = '0;
      count_setting = rlr_pkg::PARTITIONS_RESET;
      ratio_setting = rlr_pkg::RATIO_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings, dropped targets on a ring of two
      directed_targets = {6'd0, 6'd1, 6'd63, 6'd2, 6'd0, 6'd0, 6'd0, 6'd1, 6'd1};
      run_phase(30);

      // full ring, lowest ratio
      write_reg(rlr_pkg::REG_PARTITIONS, 12'd64);
      write_reg(rlr_pkg::REG_RATIO, rlr_pkg::RATIO_FLOOR);
      directed_targets = {6'd0, 6'd63, 6'd32, 6'd31, 6'd63, 6'd63, 6'd0, 6'd21, 6'd42,
                          6'd1};
      run_phase(100);

      // count below two, ratio below one, upper write bits ignored
      write_reg(rlr_pkg::REG_PARTITIONS, 12'hF80);
      write_reg(rlr_pkg::REG_RATIO, 12'd0);
      directed_targets = {6'd0, 6'd1, 6'd5, 6'd63};
      run_phase(40);

      // count beyond the ring, highest ratio
      write_reg(rlr_pkg::REG_PARTITIONS, 12'd127);
      write_reg(rlr_pkg::REG_RATIO, 12'd4095);
      run_phase(100);

      // shrink the ring, stale entries stay put
      write_reg(rlr_pkg::REG_PARTITIONS, 12'd5);
      write_reg(rlr_pkg::REG_RATIO, 12'd255);
      run_phase(60);

      // no idling on either side
      idling_on = 1'b0;
      write_reg(rlr_pkg::REG_PARTITIONS, 12'd64);
      write_reg(rlr_pkg::REG_RATIO, 12'($urandom_range(256, 4095)));
      run_phase(80);
      idling_on = 1'b1;

      // random settings
      for (k = 0; k < 2; k++) begin
         write_reg(rlr_pkg::REG_PARTITIONS, 12'($urandom_range(2, 64)));
         write_reg(rlr_pkg::REG_RATIO, 12'($urandom_range(0, 4095)));
         run_phase(40);
      end

      write_reg(rlr_pkg::REG_PARTITIONS, 12'd63);
      write_reg(rlr_pkg::REG_RATIO, rlr_pkg::RATIO_RESET);
      run_phase(60);

      // let any stray result show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_outcomes.size() != 0)
         report_mismatch("results never delivered", expected_outcomes.size(), 0);
      $display("%0d requests over %0d register settings, %0d of them rebalanced",
               requests_taken, settings_used, rebalance_seen);
      $display("counts and ratios at and beyond both ends, dropped targets, stalls");
      if (error_count == 0) begin
         $display("ring_load_rebalancer_unit: match");
      end else begin
         $display("ring_load_rebalancer_unit: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("ring_load_rebalancer_unit: mismatch");
      $finish;
   end

endmodule

/* files.f */
design/rlr_pkg.sv
design/rlr_cell.sv
design/ring_load_rebalancer_unit.sv
test/tb_ring_load_rebalancer_unit.sv
